// ----- rtl/mcad_pkg.sv -----
package mcad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 32;
  localparam int CYC_W    = 16;
  localparam int AC_W     = 3;
  localparam int CH_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int AVG_W    = 2 * BYTE_W;

  // register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_CYCLES  = 1'b1;

  // divider: quotient bits resolved per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = SUM_W / DIV_RADIX_BITS;
  localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

  localparam int JOB_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [CH_W-1:0]  chan;
    logic [SUM_W-1:0] sum;
    logic [CYC_W-1:0] den;
  } job_t;

endpackage

// ----- rtl/multichannel_average_decimator.sv -----
// Samples are taken one per cycle while the two-entry job queue has room.
// A sample that closes a channel's averaging window reaches out_valid_o via
// the job queue, the divider load, the divide steps and the output register.
// The radix-16 divider takes a new job only after finishing the previous one.
// Async active-low reset clears accumulators, pointer, round count and
// queue, and sets active_channels and average_cycles to 1.
module multichannel_average_decimator import mcad_pkg::*; #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  in_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CH_W-1:0]      out_channel_o,
  output logic [BYTE_W-1:0]    out_high_byte_o,
  output logic [BYTE_W-1:0]    out_low_byte_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CYC_W-1:0]     cfg_data_i
);

  logic [AC_W-1:0]  active_channels_q;
  logic [CYC_W-1:0] average_cycles_q;

  job_t push_job, pop_job;
  logic push, full, pop, job_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_channels_q <= AC_W'(1);
      average_cycles_q  <= CYC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ACTIVE_CHANNELS: active_channels_q <= cfg_data_i[AC_W-1:0];
        CFG_AVERAGE_CYCLES:  average_cycles_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcad_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_sample_i       (in_sample_i),
    .active_channels_i (active_channels_q),
    .average_cycles_i  (average_cycles_q),
    .job_full_i        (full),
    .job_push_o        (push),
    .job_o             (push_job)
  );

  mcad_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  mcad_div u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (pop_job),
    .job_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_channel_o   (out_channel_o),
    .out_high_byte_o (out_high_byte_o),
    .out_low_byte_o  (out_low_byte_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job_valid)
    else $error("job popped from empty queue");

  a_pop_not_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("divider loaded twice in a row");

endmodule

// ----- rtl/mcad_front.sv -----
module mcad_front import mcad_pkg::*; #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  input  logic [AC_W-1:0]     active_channels_i,
  input  logic [CYC_W-1:0]    average_cycles_i,
  input  logic                job_full_i,
  output logic                job_push_o,
  output job_t                job_o
);

  localparam int PTR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int N_W   = ($clog2(MAX_CHANNELS + 1) > AC_W) ? $clog2(MAX_CHANNELS + 1) : AC_W;

  logic [SUM_W-1:0] sums_q [MAX_CHANNELS];
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CYC_W-1:0] rc_q, rc_d;

  logic [N_W-1:0]   ac_ext, n_eff, ptr_ext, p_ext, p_inc;
  logic [PTR_W-1:0] p;
  logic [CYC_W-1:0] den, rc_inc;
  logic [SUM_W-1:0] sum;
  logic             accept, emit, last;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !job_full_i;

  always_comb begin
    ac_ext  = N_W'(active_channels_i);
    n_eff   = (ac_ext == '0) ? N_W'(1) :
              (ac_ext > N_W'(MAX_CHANNELS)) ? N_W'(MAX_CHANNELS) : ac_ext;
    ptr_ext = N_W'(ptr_q);
    // pointer left beyond the active set restarts at channel 0
    p       = (ptr_ext >= n_eff) ? '0 : ptr_q;
    p_ext   = N_W'(p);
    p_inc   = p_ext + N_W'(1);
    last    = (p_inc >= n_eff);
    ptr_d   = last ? '0 : p_inc[PTR_W-1:0];

    den     = (average_cycles_i == '0) ? CYC_W'(1) : average_cycles_i;
    emit    = ({1'b0, rc_q} + (CYC_W+1)'(1)) >= {1'b0, den};
    rc_inc  = rc_q + CYC_W'(1);
    rc_d    = rc_q;
    if (last) begin
      rc_d = (rc_inc >= den) ? '0 : rc_inc;
    end

    sum = sums_q[p] + {{(SUM_W-SAMPLE_W){in_sample_i[SAMPLE_W-1]}}, in_sample_i};
  end

  assign job_push_o = accept && emit;
  assign job_o.chan = p_ext[CH_W-1:0];
  assign job_o.sum  = sum;
  assign job_o.den  = den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      rc_q  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (accept) begin
      ptr_q     <= ptr_d;
      rc_q      <= rc_d;
      sums_q[p] <= emit ? '0 : sum;
    end
  end

endmodule

// ----- rtl/mcad_fifo.sv -----
module mcad_fifo import mcad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

  job_t             mem_q [JOB_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == CNT_W'(JOB_FIFO_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/mcad_div.sv -----
module mcad_div import mcad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CH_W-1:0]   out_channel_o,
  output logic [BYTE_W-1:0] out_high_byte_o,
  output logic [BYTE_W-1:0] out_low_byte_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [SUM_W-1:0]      quo_q;
  logic [CYC_W-1:0]      rem_q, den_q;
  logic                  neg_q;
  logic [CH_W-1:0]       chan_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic                  out_valid_q;
  logic [CH_W-1:0]       out_chan_q;
  logic [AVG_W-1:0]      out_avg_q;

  logic [SUM_W-1:0] q_nx, mag;
  logic [CYC_W-1:0] r_nx;
  logic [CYC_W:0]   r_wide;
  logic [AVG_W-1:0] avg;
  logic             out_free, load;

  // restoring division, DIV_RADIX_BITS quotient bits per cycle
  always_comb begin
    r_nx   = rem_q;
    q_nx   = quo_q;
    r_wide = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r_wide = {r_nx, q_nx[SUM_W-1]};
      q_nx   = {q_nx[SUM_W-2:0], 1'b0};
      if (r_wide >= {1'b0, den_q}) begin
        r_wide  = r_wide - {1'b0, den_q};
        q_nx[0] = 1'b1;
      end
      r_nx = r_wide[CYC_W-1:0];
    end
  end

  assign mag      = job_i.sum[SUM_W-1] ? (SUM_W'(0) - job_i.sum) : job_i.sum;
  assign avg      = neg_q ? (AVG_W'(0) - quo_q[AVG_W-1:0]) : quo_q[AVG_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = job_valid_i &&
                    ((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));
  assign job_pop_o = load;

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_chan_q;
  assign out_high_byte_o = out_avg_q[AVG_W-1:BYTE_W];
  assign out_low_byte_o  = out_avg_q[BYTE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quo_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      neg_q       <= 1'b0;
      chan_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_chan_q  <= '0;
      out_avg_q   <= '0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        quo_q  <= mag;
        rem_q  <= '0;
        den_q  <= job_i.den;
        neg_q  <= job_i.sum[SUM_W-1];
        chan_q <= job_i.chan;
        step_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (load) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q  <= q_nx;
          rem_q  <= r_nx;
          step_q <= step_q + DIV_STEP_W'(1);
          if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_chan_q  <= chan_q;
            out_avg_q   <= avg;
            state_q     <= load ? ST_DIV : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
